// ----- src/arc_pkg.sv -----
// Shared types and constants for the ambient report-on-change block.
// No dependencies; every other file in src imports this package.
package arc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TOL         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_TOL          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TOL        = 3'd4;

    localparam logic [31:0] MEASURE_PERIOD_RST   = 32'd1000;
    localparam logic [31:0] HEARTBEAT_PERIOD_RST = 32'd60000;
    localparam logic [15:0] TEMP_TOL_RST         = 16'd50;
    localparam logic [15:0] HUM_TOL_RST          = 16'd2;
    localparam logic [15:0] LIGHT_TOL_RST        = 16'd20;

    // Last-sent values start at the far end so the first check reports unless the readings lie near it too.
    localparam logic signed [15:0] SENT_TEMP_RST  = 16'sh8000;
    localparam logic [15:0]        SENT_LEVEL_RST = 16'hFFFF;

    localparam logic FRAME_VALUES = 1'b0;
    localparam logic FRAME_ERROR  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TEMP  = 3'd1,
        PH_HUM   = 3'd2,
        PH_CHECK = 3'd3,
        PH_SEND  = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    typedef struct packed {
        logic [31:0] measure_period;
        logic [31:0] heartbeat_period;
        logic [15:0] temp_tolerance;
        logic [15:0] hum_tolerance;
        logic [15:0] light_tolerance;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [15:0]        light_level;
        logic               temp_ok;
        logic signed [15:0] temp_reading;
        logic               hum_ok;
        logic [15:0]        hum_reading;
    } item_t;

    typedef struct packed {
        logic               frame_kind;
        logic signed [15:0] rep_temperature;
        logic [15:0]        rep_humidity;
        logic [15:0]        rep_light;
    } frame_t;

    // Handshake between the pipeline control in the top level and the core.
    typedef struct packed {
        logic fire;  // item in the input register is processed this cycle
    } core_ctl_t;

    typedef struct packed {
        logic emit;  // the held item, if processed, produces a frame
    } core_sts_t;

endpackage

// ----- src/ambient_report_on_change.sv -----
// Ambient report-on-change: each tick request carries the time, a filtered light
// level and sensor read results; the block steps idle, temperature, humidity,
// check, send and error phases, one phase per request, and emits a value frame
// when a reading moved past its tolerance or the heartbeat period expired, or an
// error frame after a failed read. A request is registered in the input register
// on acceptance and processed by one pass of subtract/compare logic; a frame that it
// produces is loaded into the frame register, which raises frame_valid. The block
// takes one request per clock while no held request waits for the frame register.
// Requests that produce no frame keep flowing even while a frame waits on
// frame_stall; a request that would produce a frame waits in the input register
// until the frame register frees up. Configuration is written through cfg_valid /
// cfg_ready (always ready) and must only change while the block is idle.
// Depends on arc_pkg, arc_cfg, arc_in_stage, arc_core, arc_out_stage.
module ambient_report_on_change (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,

    // tick request channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [31:0]                   now_ms,
    input  logic [15:0]                   light_level,
    input  logic                          temp_ok,
    input  logic signed [15:0]            temp_reading,
    input  logic                          hum_ok,
    input  logic [15:0]                   hum_reading,

    // frame channel
    output logic                          frame_valid,
    input  logic                          frame_stall,
    output logic                          frame_kind,
    output logic signed [15:0]            rep_temperature,
    output logic [15:0]                   rep_humidity,
    output logic [15:0]                   rep_light
);
    import arc_pkg::*;

    cfg_t      cfg;
    item_t     item_in;
    item_t     held_item;
    logic      held_valid;
    core_ctl_t ctl;
    core_sts_t sts;
    frame_t    core_frame;
    frame_t    out_frame;
    logic      out_free;

    assign item_in.now_ms       = now_ms;
    assign item_in.light_level  = light_level;
    assign item_in.temp_ok      = temp_ok;
    assign item_in.temp_reading = temp_reading;
    assign item_in.hum_ok       = hum_ok;
    assign item_in.hum_reading  = hum_reading;

    // Process the held request unless it makes a frame and the frame register is full.
    assign ctl.fire = held_valid && (!sts.emit || out_free);

    arc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    arc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .ctl        (ctl),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    arc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (held_item),
        .ctl   (ctl),
        .sts   (sts),
        .frame (core_frame)
    );

    arc_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ctl.fire && sts.emit),
        .frame_in    (core_frame),
        .free        (out_free),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_out   (out_frame)
    );

    assign frame_kind      = out_frame.frame_kind;
    assign rep_temperature = out_frame.rep_temperature;
    assign rep_humidity    = out_frame.rep_humidity;
    assign rep_light       = out_frame.rep_light;

    // A stalled frame is never overwritten by a newly processed one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |-> !(ctl.fire && sts.emit))
        else $error("frame register overwritten while stalled");

    // The input side only stalls while it holds a request.
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> held_valid)
        else $error("request stalled with empty input register");

    // Error frames carry zero payload.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_kind == FRAME_ERROR |->
            rep_temperature == '0 && rep_humidity == '0 && rep_light == '0)
        else $error("error frame with nonzero payload");

endmodule

// ----- src/arc_cfg.sv -----
// Configuration register file for the ambient report-on-change block.
// Depends on arc_pkg.
module arc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output arc_pkg::cfg_t                 cfg
);
    import arc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MEASURE_PERIOD:   cfg_next.measure_period   = cfg_data;
                CFG_HEARTBEAT_PERIOD: cfg_next.heartbeat_period = cfg_data;
                CFG_TEMP_TOL:         cfg_next.temp_tolerance   = cfg_data[15:0];
                CFG_HUM_TOL:          cfg_next.hum_tolerance    = cfg_data[15:0];
                CFG_LIGHT_TOL:        cfg_next.light_tolerance  = cfg_data[15:0];
                default:              cfg_next = cfg_reg;  // unknown index dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measure_period   <= MEASURE_PERIOD_RST;
            cfg_reg.heartbeat_period <= HEARTBEAT_PERIOD_RST;
            cfg_reg.temp_tolerance   <= TEMP_TOL_RST;
            cfg_reg.hum_tolerance    <= HUM_TOL_RST;
            cfg_reg.light_tolerance  <= LIGHT_TOL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/arc_in_stage.sv -----
// Input register for tick requests; holds one request until the core takes it.
// Depends on arc_pkg.
module arc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  arc_pkg::item_t     item_in,
    input  arc_pkg::core_ctl_t ctl,
    output logic               held_valid,
    output arc_pkg::item_t     held_item
);
    import arc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Free when empty or when the held request leaves this cycle.
    assign item_stall = valid_reg && !ctl.fire;
    assign accept     = item_valid && !item_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (ctl.fire)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_in;
    end

endmodule

// ----- src/arc_core.sv -----
// Phase sequencer, change detection and report state of the block.
// Depends on arc_pkg.
module arc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  arc_pkg::cfg_t      cfg,
    input  arc_pkg::item_t     item,
    input  arc_pkg::core_ctl_t ctl,
    output arc_pkg::core_sts_t sts,
    output arc_pkg::frame_t    frame
);
    import arc_pkg::*;

    phase_t             phase_reg,           phase_next;
    logic [31:0]        measure_start_reg,   measure_start_next;
    logic [31:0]        heartbeat_start_reg, heartbeat_start_next;
    logic signed [15:0] cur_temp_reg,        cur_temp_next;
    logic [15:0]        cur_hum_reg,         cur_hum_next;
    logic signed [15:0] sent_temp_reg,       sent_temp_next;
    logic [15:0]        sent_hum_reg,        sent_hum_next;
    logic [15:0]        sent_light_reg,      sent_light_next;

    logic               measure_due;
    logic               heartbeat_due;
    logic signed [16:0] temp_delta;
    logic [16:0]        temp_abs;
    logic [15:0]        hum_abs;
    logic [15:0]        light_abs;
    logic               changed;

    // Elapsed time is modulo 2^32, so a plain subtract is wrap-safe.
    assign measure_due   = (item.now_ms - measure_start_reg) >= cfg.measure_period;
    assign heartbeat_due = (item.now_ms - heartbeat_start_reg) >= cfg.heartbeat_period;

    assign temp_delta = {cur_temp_reg[15], cur_temp_reg} - {sent_temp_reg[15], sent_temp_reg};
    assign temp_abs   = temp_delta[16] ? 17'(-temp_delta) : 17'(temp_delta);
    assign hum_abs    = (cur_hum_reg > sent_hum_reg) ? cur_hum_reg - sent_hum_reg
                                                     : sent_hum_reg - cur_hum_reg;
    assign light_abs  = (item.light_level > sent_light_reg)
                      ? item.light_level - sent_light_reg
                      : sent_light_reg - item.light_level;
    assign changed    = (temp_abs > {1'b0, cfg.temp_tolerance})
                     || (hum_abs > cfg.hum_tolerance)
                     || (light_abs > cfg.light_tolerance);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (ctl.fire)
        begin
            case (phase_reg)
                PH_IDLE:  phase_next = measure_due ? PH_TEMP : PH_IDLE;
                PH_TEMP:  phase_next = item.temp_ok ? PH_HUM : PH_ERROR;
                PH_HUM:   phase_next = item.hum_ok ? PH_CHECK : PH_ERROR;
                PH_CHECK: phase_next = (changed || heartbeat_due) ? PH_SEND : PH_IDLE;
                PH_SEND:  phase_next = PH_IDLE;
                PH_ERROR: phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath and frame outputs
    always_comb
    begin
        measure_start_next   = measure_start_reg;
        heartbeat_start_next = heartbeat_start_reg;
        cur_temp_next        = cur_temp_reg;
        cur_hum_next         = cur_hum_reg;
        sent_temp_next       = sent_temp_reg;
        sent_hum_next        = sent_hum_reg;
        sent_light_next      = sent_light_reg;
        sts.emit             = 1'b0;
        frame                = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (ctl.fire && measure_due)
                    measure_start_next = item.now_ms;
            end
            PH_TEMP:
            begin
                if (ctl.fire && item.temp_ok)
                    cur_temp_next = item.temp_reading;
            end
            PH_HUM:
            begin
                if (ctl.fire && item.hum_ok)
                    cur_hum_next = item.hum_reading;
            end
            PH_SEND:
            begin
                sts.emit              = 1'b1;
                frame.frame_kind      = FRAME_VALUES;
                frame.rep_temperature = cur_temp_reg;
                frame.rep_humidity    = cur_hum_reg;
                frame.rep_light       = item.light_level;
                if (ctl.fire)
                begin
                    sent_temp_next       = cur_temp_reg;
                    sent_hum_next        = cur_hum_reg;
                    sent_light_next      = item.light_level;
                    heartbeat_start_next = item.now_ms;
                end
            end
            PH_ERROR:
            begin
                sts.emit         = 1'b1;
                frame.frame_kind = FRAME_ERROR;
            end
            default:
            begin
                sts.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            measure_start_reg   <= '0;
            heartbeat_start_reg <= '0;
            cur_temp_reg        <= '0;
            cur_hum_reg         <= '0;
            sent_temp_reg       <= SENT_TEMP_RST;
            sent_hum_reg        <= SENT_LEVEL_RST;
            sent_light_reg      <= SENT_LEVEL_RST;
        end
        else
        begin
            phase_reg           <= phase_next;
            measure_start_reg   <= measure_start_next;
            heartbeat_start_reg <= heartbeat_start_next;
            cur_temp_reg        <= cur_temp_next;
            cur_hum_reg         <= cur_hum_next;
            sent_temp_reg       <= sent_temp_next;
            sent_hum_reg        <= sent_hum_next;
            sent_light_reg      <= sent_light_next;
        end
    end

    // A sent frame becomes the new reference and restarts the heartbeat.
    a_send_updates: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && phase_reg == PH_SEND |=>
            sent_light_reg == $past(item.light_level)
            && heartbeat_start_reg == $past(item.now_ms)
            && phase_reg == PH_IDLE)
        else $error("send did not update reference state");

    // Error path leaves timers and reference values alone.
    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && phase_reg == PH_ERROR |=>
            $stable(heartbeat_start_reg) && $stable(sent_temp_reg)
            && $stable(measure_start_reg) && phase_reg == PH_IDLE)
        else $error("error frame disturbed report state");

    // A failed read never overwrites the current value.
    a_failed_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && phase_reg == PH_TEMP && !item.temp_ok |=>
            $stable(cur_temp_reg) && phase_reg == PH_ERROR)
        else $error("failed temperature read stored");

endmodule

// ----- src/arc_out_stage.sv -----
// Result register for outgoing frames; holds a frame while the sink stalls.
// Depends on arc_pkg.
module arc_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  arc_pkg::frame_t frame_in,
    output logic            free,
    output logic            frame_valid,
    input  logic            frame_stall,
    output arc_pkg::frame_t frame_out
);
    import arc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    assign free        = !valid_reg || !frame_stall;
    assign frame_valid = valid_reg;
    assign frame_out   = frame_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!frame_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frame_in;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for ambient_report_on_change: drives tick requests and register writes,
// predicts every value and error frame, and compares them as they leave the block.
// Depends on arc_pkg and the RTL under src.
module tb_top;
    import arc_pkg::*;

    // Register indexes past the last defined one; writes to them must be ignored.
    localparam int CFG_IDX_SPARE_LO = int'(CFG_LIGHT_TOL) + 1;
    localparam int CFG_IDX_SPARE_HI = (1 << CFG_IDX_W) - 1;
    // Cycles allowed for ticks that make no frame to leave the pipeline.
    localparam int DRAIN_CYCLES     = 8;
    localparam int SETTLE_LIMIT     = 5000;
    localparam int LONG_HOLD        = 400;

    // Tracks the block's phase sequence and holds the frames it must emit, oldest first.
    class report_tracker;
        logic [31:0]        meas_period;
        logic [31:0]        hb_period;
        logic [15:0]        temp_tol;
        logic [15:0]        hum_tol;
        logic [15:0]        light_tol;
        phase_t             phase;
        logic [31:0]        meas_start;
        logic [31:0]        hb_start;
        logic signed [15:0] cur_temp;
        logic [15:0]        cur_hum;
        logic signed [15:0] sent_temp;
        logic [15:0]        sent_hum;
        logic [15:0]        sent_light;
        frame_t             frames_due[$];
        int unsigned        failures;
        int unsigned        frames_seen;

        function new();
            meas_period = MEASURE_PERIOD_RST;
            hb_period   = HEARTBEAT_PERIOD_RST;
            temp_tol    = TEMP_TOL_RST;
            hum_tol     = HUM_TOL_RST;
            light_tol   = LIGHT_TOL_RST;
            phase       = PH_IDLE;
            meas_start  = '0;
            hb_start    = '0;
            cur_temp    = '0;
            cur_hum     = '0;
            sent_temp   = SENT_TEMP_RST;
            sent_hum    = SENT_LEVEL_RST;
            sent_light  = SENT_LEVEL_RST;
            failures    = 0;
            frames_seen = 0;
        endfunction

        function int unsigned abs_gap(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int unsigned pending();
            return frames_due.size();
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MEASURE_PERIOD:   meas_period = data;
                CFG_HEARTBEAT_PERIOD: hb_period   = data;
                CFG_TEMP_TOL:         temp_tol    = data[15:0];
                CFG_HUM_TOL:          hum_tol     = data[15:0];
                CFG_LIGHT_TOL:        light_tol   = data[15:0];
                default:              ;
            endcase
        endfunction

        // One accepted tick request advances the sequence by one phase.
        function void take_tick(item_t it);
            logic [31:0] span;
            logic        changed;
            frame_t      f;
            case (phase)
                PH_IDLE:
                begin
                    span = it.now_ms - meas_start;
                    if (span >= meas_period)
                    begin
                        meas_start = it.now_ms;
                        phase      = PH_TEMP;
                    end
                end
                PH_TEMP:
                begin
                    if (it.temp_ok)
                    begin
                        cur_temp = it.temp_reading;
                        phase    = PH_HUM;
                    end
                    else
                        phase = PH_ERROR;
                end
                PH_HUM:
                begin
                    if (it.hum_ok)
                    begin
                        cur_hum = it.hum_reading;
                        phase   = PH_CHECK;
                    end
                    else
                        phase = PH_ERROR;
                end
                PH_CHECK:
                begin
                    changed = abs_gap(cur_temp, sent_temp) > temp_tol
                        || abs_gap(cur_hum, sent_hum) > hum_tol
                        || abs_gap(it.light_level, sent_light) > light_tol;
                    span  = it.now_ms - hb_start;
                    phase = (changed || span >= hb_period) ? PH_SEND : PH_IDLE;
                end
                PH_SEND:
                begin
                    f.frame_kind      = FRAME_VALUES;
                    f.rep_temperature = cur_temp;
                    f.rep_humidity    = cur_hum;
                    f.rep_light       = it.light_level;
                    frames_due.push_back(f);
                    sent_temp  = cur_temp;
                    sent_hum   = cur_hum;
                    sent_light = it.light_level;
                    hb_start   = it.now_ms;
                    phase      = PH_IDLE;
                end
                PH_ERROR:
                begin
                    f = '0;
                    f.frame_kind = FRAME_ERROR;
                    frames_due.push_back(f);
                    phase = PH_IDLE;
                end
                default:
                    phase = PH_IDLE;
            endcase
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                if (failures < 10)
                    $display("frame %0d: none expected, got kind %0d temp %0d hum %0d light %0d",
                        frames_seen, got.frame_kind, got.rep_temperature, got.rep_humidity,
                        got.rep_light);
                failures++;
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_kind !== want.frame_kind
                || got.rep_temperature !== want.rep_temperature
                || got.rep_humidity !== want.rep_humidity
                || got.rep_light !== want.rep_light)
            begin
                if (failures < 10)
                    $display({"frame %0d: kind %0d/%0d temp %0d/%0d hum %0d/%0d light %0d/%0d",
                        " (expected/actual)"}, frames_seen,
                        want.frame_kind, got.frame_kind, want.rep_temperature,
                        got.rep_temperature, want.rep_humidity, got.rep_humidity,
                        want.rep_light, got.rep_light);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]           cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    logic [31:0]           now_ms;
    logic [15:0]           light_level;
    logic                  temp_ok;
    logic signed [15:0]    temp_reading;
    logic                  hum_ok;
    logic [15:0]           hum_reading;
    logic                  frame_valid;
    logic                  frame_stall;
    logic                  frame_kind;
    logic signed [15:0]    rep_temperature;
    logic [15:0]           rep_humidity;
    logic [15:0]           rep_light;

    report_tracker reports = new();

    // Sender's running millisecond time; random ticks mostly move it forward a little.
    logic [31:0] clock_ms;
    int unsigned tx_quiet;
    // Long receiver hold-offs requested by the sender; the receiver counts them out.
    int unsigned hold_reqs;

    ambient_report_on_change i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Gap before the next request: mostly none or short, now and then long,
    // with stretches of back-to-back requests.
    function automatic int unsigned tx_gap();
        int unsigned r;
        if (tx_quiet != 0)
        begin
            tx_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            tx_quiet = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Value near a reference, straddling the tolerance, or anywhere in 16 bits.
    function automatic logic [15:0] near16(logic [15:0] center, logic [15:0] tol);
        int span;
        int off;
        if ($urandom_range(0, 99) >= 70)
            return 16'($urandom);
        span = int'(tol) + 2;
        off  = $urandom_range(0, 2 * span);
        off  = off - span;
        return center + off[15:0];
    endfunction

    function automatic logic [15:0] rand_tol();
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(0, 60));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random tick: time steps hit the measure and heartbeat boundaries exactly
    // (and one short of them) often enough; readings cluster around the last
    // reported values so both sides of every tolerance come up.
    function automatic item_t rand_tick();
        item_t       it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, 30);
        else if (r < 80)
            clock_ms = reports.meas_start + reports.meas_period - $urandom_range(0, 1);
        else if (r < 88)
            clock_ms = reports.hb_start + reports.hb_period - $urandom_range(0, 1);
        else if (r < 95)
            clock_ms = clock_ms + $urandom_range(100, 70000);
        else
            clock_ms = $urandom;
        it.now_ms       = clock_ms;
        it.light_level  = near16(reports.sent_light, reports.light_tol);
        it.temp_ok      = ($urandom_range(0, 19) != 0);
        it.temp_reading = near16(reports.sent_temp, reports.temp_tol);
        it.hum_ok       = ($urandom_range(0, 19) != 0);
        it.hum_reading  = near16(reports.sent_hum, reports.hum_tol);
        return it;
    endfunction

    // Entered and left at a falling edge; valid stays high across back-to-back requests.
    task automatic drive_tick(input item_t it);
        int unsigned gap;
        gap = tx_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        now_ms       <= it.now_ms;
        light_level  <= it.light_level;
        temp_ok      <= it.temp_ok;
        temp_reading <= it.temp_reading;
        hum_ok       <= it.hum_ok;
        hum_reading  <= it.hum_reading;
        do
            @(posedge clk);
        while (item_stall);
        reports.take_tick(it);
        @(negedge clk);
    endtask

    task automatic tick(input logic [31:0] t_now, input logic [15:0] lux, input logic tok,
                        input logic [15:0] tval, input logic hok, input logic [15:0] hval);
        item_t it;
        it.now_ms       = t_now;
        it.light_level  = lux;
        it.temp_ok      = tok;
        it.temp_reading = tval;
        it.hum_ok       = hok;
        it.hum_reading  = hval;
        drive_tick(it);
    endtask

    // Stop sending, wait for every frame still owed, then give ticks that make
    // no frame time to leave the pipeline.
    task automatic settle();
        int unsigned n;
        item_valid <= 1'b0;
        n = 0;
        while (reports.pending() != 0 && n < SETTLE_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reports.note_write(idx, data);
        @(negedge clk);
    endtask

    // Tolerance writes carry junk in the upper half, which the block must drop.
    task automatic reconfigure(input logic [31:0] mp, input logic [31:0] hp,
                               input logic [15:0] tt, input logic [15:0] ht,
                               input logic [15:0] lt, input bit spare);
        int i;
        settle();
        write_reg(CFG_MEASURE_PERIOD, mp);
        write_reg(CFG_HEARTBEAT_PERIOD, hp);
        write_reg(CFG_TEMP_TOL, {16'($urandom), tt});
        write_reg(CFG_HUM_TOL, {16'($urandom), ht});
        write_reg(CFG_LIGHT_TOL, {16'($urandom), lt});
        if (spare)
            for (i = CFG_IDX_SPARE_LO; i <= CFG_IDX_SPARE_HI; i++)
                write_reg(i[CFG_IDX_W-1:0], $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stall bursts, quiet stretches, and long hold-offs on request.
    initial
    begin : rx_side
        int unsigned left;
        int unsigned quiet;
        int unsigned hold_done;
        int unsigned r;
        left        = 0;
        quiet       = 0;
        hold_done   = 0;
        frame_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_done)
            begin
                hold_done = hold_reqs;
                left      = LONG_HOLD;
            end
            else if (left == 0)
            begin
                if (quiet != 0)
                    quiet--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        quiet = $urandom_range(20, 80);
                    else if (r < 35)
                        left = $urandom_range(1, 3);
                    else if (r < 38)
                        left = $urandom_range(20, 60);
                end
            end
            if (left != 0)
            begin
                frame_stall <= 1'b1;
                left--;
            end
            else
                frame_stall <= 1'b0;
        end
    end

    // Frames are taken at the rising edge where valid is high and stall low.
    always @(posedge clk)
    begin : frame_monitor
        if (rst_n && frame_valid && !frame_stall)
            reports.check_frame({frame_kind, rep_temperature, rep_humidity, rep_light});
    end

    initial
    begin : stimulus
        int k;
        int n;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        now_ms       = '0;
        light_level  = '0;
        temp_ok      = 1'b0;
        temp_reading = '0;
        hum_ok       = 1'b0;
        hum_reading  = '0;
        tx_quiet     = 0;
        hold_reqs    = 0;
        clock_ms     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed ticks at reset settings. First check after reset reports
        // because the last-sent values start at the far ends.
        tick(32'd0, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd999, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);        // one short of the period
        tick(32'd1000, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);       // period exactly elapsed
        tick(32'd1001, 16'd0, 1'b1, 16'h7FFF, 1'b1, 16'd0);    // hottest reading
        tick(32'd1002, 16'd0, 1'b1, 16'd0, 1'b1, 16'hFFFF);    // full humidity
        tick(32'd1003, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd1004, 16'hFFFF, 1'b1, 16'd0, 1'b1, 16'd0);    // value frame, light max
        tick(32'd2000, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd2001, 16'd0, 1'b1, 16'h8000, 1'b1, 16'd0);    // coldest reading
        tick(32'd2002, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd2003, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd2004, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd3004, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd3005, 16'd0, 1'b0, 16'h1234, 1'b1, 16'd0);    // temperature read fails
        tick(32'd3006, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);       // error frame
        tick(32'd4006, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd4007, 16'd0, 1'b1, 16'h8032, 1'b1, 16'd0);    // change equals tolerance
        tick(32'd4008, 16'd0, 1'b1, 16'd0, 1'b1, 16'd2);
        tick(32'd4009, 16'd20, 1'b1, 16'd0, 1'b1, 16'd0);      // nothing past tolerance
        tick(32'd5009, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'd5010, 16'd0, 1'b1, 16'h8033, 1'b1, 16'd0);
        tick(32'd5011, 16'd0, 1'b1, 16'd0, 1'b0, 16'd3);       // humidity read fails
        tick(32'd5012, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);
        tick(32'hFFFF_FFFF, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0);  // time near the wrap
        tick(32'hFFFF_FFFF, 16'd0, 1'b1, 16'h8033, 1'b1, 16'd0);
        tick(32'd0, 16'd0, 1'b1, 16'd0, 1'b1, 16'd3);          // time wraps past zero
        tick(32'd1, 16'd21, 1'b1, 16'd0, 1'b1, 16'd0);         // light just past tolerance
        tick(32'd2, 16'd21, 1'b1, 16'd0, 1'b1, 16'd0);
        clock_ms = 32'd2;

        // Zero periods and tolerances: every tick moves on and every check reports.
        reconfigure(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        for (n = 0; n < 100; n++)
            drive_tick(rand_tick());

        // Largest periods and tolerances: only the exact boundary gets through.
        reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        for (n = 0; n < 60; n++)
            drive_tick(rand_tick());

        for (k = 0; k < 6; k++)
        begin
            reconfigure($urandom_range(0, 40),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300),
                        rand_tol(), rand_tol(), rand_tol(), 1'b0);
            for (n = 0; n < 100; n++)
            begin
                // Receiver holds off while requests keep coming, so the block backs up.
                if (k == 1 && n == 30)
                    hold_reqs++;
                // Sender pauses until every owed frame is out.
                if (k == 3 && n == 50)
                    settle();
                drive_tick(rand_tick());
            end
        end

        reconfigure(MEASURE_PERIOD_RST, HEARTBEAT_PERIOD_RST, TEMP_TOL_RST, HUM_TOL_RST,
                    LIGHT_TOL_RST, 1'b0);
        for (n = 0; n < 60; n++)
            drive_tick(rand_tick());

        settle();
        if (reports.pending() != 0)
        begin
            $display("%0d frames never arrived", reports.pending());
            reports.failures += reports.pending();
        end
        if (reports.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/arc_pkg.sv
src/arc_cfg.sv
src/arc_in_stage.sv
src/arc_core.sv
src/arc_out_stage.sv
src/ambient_report_on_change.sv
test/tb_top.sv
